// ----- rtl/core/tccs_pkg.sv -----
// Shared constants, request codes and controller/datapath bundles for the
// text console core. No dependencies; compiled first.
package tccs_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] RESET_COLOR  = 8'd10;

  typedef enum logic [1:0] {
    REQ_PUT_CHAR = 2'd0,
    REQ_PUT_CELL = 2'd1,
    REQ_READ     = 2'd2,
    REQ_NOP      = 2'd3
  } req_type_t;

  typedef struct packed {
    logic load_req;
    logic exec;
    logic sweep_init;
    logic sweep_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scroll_now;
    logic sweep_last;
  } ctrl_sts_t;

endpackage

// ----- rtl/core/tccs_req_if.sv -----
// Request channel interface: valid/ready handshake plus the request payload.
// Depends on tccs_pkg.
interface tccs_req_if;
  import tccs_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [CHAR_W-1:0] char_code;
  logic [ATTR_W-1:0] cell_color;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;

  modport source (output valid, req_type, char_code, cell_color, col, row, input ready);
  modport sink   (input valid, req_type, char_code, cell_color, col, row, output ready);
endinterface

// ----- rtl/core/tccs_rsp_if.sv -----
// Result channel interface: valid/ready handshake plus the result payload.
// Depends on tccs_pkg.
interface tccs_rsp_if;
  import tccs_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] read_char;
  logic [ATTR_W-1:0] read_color;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic              scrolled;

  modport source (output valid, read_char, read_color, cursor_row, cursor_col, scrolled,
                  input ready);
  modport sink   (input valid, read_char, read_color, cursor_row, cursor_col, scrolled,
                  output ready);
endinterface

// ----- rtl/core/tccs_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/tccs_ctrl.sv -----
// Sequencing controller: clear pass after reset, request execution, scroll
// line clear and result handoff. Depends on tccs_pkg.
module tccs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tccs_pkg::ctrl_sts_t  sts,
  output tccs_pkg::ctrl_cmd_t  cmd
);
  import tccs_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        cmd.sweep_init = 1'b1;
        state_nxt      = S_CLEAR;
      end
      S_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.load_req = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.scroll_now ? S_SCROLL : S_FIN;
      end
      S_SCROLL: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.out_load = !out_valid_r || out_ready;
        if (cmd.out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/tccs_dp.sv -----
// Datapath: request and cursor registers, scroll offset, address mapping,
// clear sweep and the screen cell RAM. Depends on tccs_pkg and tccs_ram.
module tccs_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tccs_pkg::ctrl_cmd_t           cmd,
  output tccs_pkg::ctrl_sts_t           sts,
  input  logic [1:0]                    in_req_type,
  input  logic [tccs_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tccs_pkg::ATTR_W-1:0]   in_cell_color,
  input  logic [tccs_pkg::COL_W-1:0]    in_col,
  input  logic [tccs_pkg::ROW_W-1:0]    in_row,
  input  logic                          cfg_wr_en,
  input  logic [tccs_pkg::ATTR_W-1:0]   cfg_wr_data,
  output logic [tccs_pkg::CHAR_W-1:0]   out_read_char,
  output logic [tccs_pkg::ATTR_W-1:0]   out_read_color,
  output logic [tccs_pkg::ROW_W-1:0]    out_cursor_row,
  output logic [tccs_pkg::COL_W-1:0]    out_cursor_col,
  output logic                          out_scrolled
);
  import tccs_pkg::*;

  req_type_t         req_type_r;
  logic [CHAR_W-1:0] char_r;
  logic [ATTR_W-1:0] attr_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;

  logic [ATTR_W-1:0] text_color_r;
  logic [ROW_W-1:0]  top_r, top_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic              scrolled_r;
  logic              rd_valid_r;

  logic [ADDR_W-1:0] sweep_r;
  logic [ADDR_W-1:0] sweep_base_r;
  logic              sweep_rst_r;

  logic [CHAR_W-1:0] out_char_r;
  logic [ATTR_W-1:0] out_color_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic              out_scrolled_r;

  logic              is_put_char, is_newline, col_wrap, adv_row, at_bottom;
  logic              scroll_now, in_range, exec_we, exec_re;
  logic [COL_W:0]    col_inc;
  logic [ROW_W-1:0]  log_row, phys_row;
  logic [COL_W-1:0]  log_col;
  logic [ROW_W:0]    row_sum;
  logic [ADDR_W-1:0] cell_addr, top_base, sweep_addr;
  logic [CELL_W-1:0] exec_wdata, sweep_wdata;
  logic [ATTR_W-1:0] sweep_color;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    is_put_char = (req_type_r == REQ_PUT_CHAR);
    is_newline  = (char_r == NEWLINE_CODE);
    col_inc     = {1'b0, cur_col_r} + 1'b1;
    col_wrap    = (col_inc == (COL_W+1)'(COLUMNS));
    adv_row     = is_put_char && (is_newline || col_wrap);
    at_bottom   = (cur_row_r == ROW_W'(ROWS - 1));
    scroll_now  = adv_row && at_bottom;
    in_range    = ({1'b0, col_r} < (COL_W+1)'(COLUMNS)) &&
                  ({1'b0, row_r} < (ROW_W+1)'(ROWS));

    log_row  = is_put_char ? cur_row_r : row_r;
    log_col  = is_put_char ? cur_col_r : col_r;
    row_sum  = {1'b0, top_r} + {1'b0, log_row};
    phys_row = (row_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(row_sum - (ROW_W+1)'(ROWS))
                                               : ROW_W'(row_sum);
    cell_addr = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(log_col);
    top_base  = ADDR_W'(top_r) * ADDR_W'(COLUMNS);

    exec_we    = is_put_char ? !is_newline : ((req_type_r == REQ_PUT_CELL) && in_range);
    exec_re    = (req_type_r == REQ_READ) && in_range;
    exec_wdata = is_put_char ? {text_color_r, char_r} : {attr_r, char_r};

    sweep_addr  = sweep_base_r + sweep_r;
    sweep_color = sweep_rst_r ? RESET_COLOR : text_color_r;
    sweep_wdata = {sweep_color, SPACE_CODE};

    cur_col_nxt = !is_put_char ? cur_col_r :
                  (is_newline || col_wrap) ? '0 : COL_W'(col_inc);
    cur_row_nxt = (adv_row && !at_bottom) ? cur_row_r + 1'b1 : cur_row_r;
    top_nxt     = !scroll_now ? top_r :
                  (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + 1'b1;

    sts.scroll_now = scroll_now;
    sts.sweep_last = (sweep_r == (sweep_rst_r ? ADDR_W'(CELLS - 1) : ADDR_W'(COLUMNS - 1)));

    ram_we    = cmd.sweep_step || (cmd.exec && exec_we);
    ram_waddr = cmd.sweep_step ? sweep_addr : cell_addr;
    ram_wdata = cmd.sweep_step ? sweep_wdata : exec_wdata;
    ram_re    = cmd.exec && exec_re;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= RESET_COLOR;
      top_r        <= '0;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        text_color_r <= cfg_wr_data;
      end
      if (cmd.exec) begin
        top_r     <= top_nxt;
        cur_row_r <= cur_row_nxt;
        cur_col_r <= cur_col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type_r <= req_type_t'(in_req_type);
      char_r     <= in_char_code;
      attr_r     <= in_cell_color;
      col_r      <= in_col;
      row_r      <= in_row;
    end
    if (cmd.exec) begin
      scrolled_r <= scroll_now;
      rd_valid_r <= exec_re;
    end
    if (cmd.sweep_init) begin
      sweep_r      <= '0;
      sweep_base_r <= '0;
      sweep_rst_r  <= 1'b1;
    end else if (cmd.exec && scroll_now) begin
      sweep_r      <= '0;
      sweep_base_r <= top_base;
      sweep_rst_r  <= 1'b0;
    end else if (cmd.sweep_step) begin
      sweep_r <= sweep_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_char_r     <= rd_valid_r ? ram_rdata[CHAR_W-1:0] : '0;
      out_color_r    <= rd_valid_r ? ram_rdata[CELL_W-1:CHAR_W] : '0;
      out_row_r      <= cur_row_r;
      out_col_r      <= cur_col_r;
      out_scrolled_r <= scrolled_r;
    end
  end

  tccs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cell_addr),
    .rdata (ram_rdata)
  );

  assign out_read_char  = out_char_r;
  assign out_read_color = out_color_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_scrolled   = out_scrolled_r;

endmodule

// ----- rtl/core/text_console_cursor_scroll.sv -----
// Top level of the text console core: controller, datapath and checks.
// Depends on tccs_pkg, tccs_req_if, tccs_rsp_if, tccs_ctrl and tccs_dp.
//
// Requests arrive on in_ch, one beat per request: put a character at the
// cursor, put a cell at a position, read a cell or do nothing. Every request gives
// exactly one result beat on out_ch with the read data and the cursor.
// The attribute for put-character and scroll clearing is written through
// cfg_wr_en / cfg_wr_data.
// After accept, a request is executed against the cell RAM and its result
// is then loaded into the output register. A request that scrolls also
// clears the new bottom line first, one RAM write per cycle. Scrolling
// itself moves a top-row offset instead of copying rows. One request is
// in flight at a time.
// After reset the core runs a clearing pass over all cells, one per cycle,
// with in_ch.ready low. The output register holds a result while
// out_ch.ready is low; the next request is still accepted and waits for the
// register to free up before its own result is loaded.
module text_console_cursor_scroll (
  input  logic                        clk,
  input  logic                        rst_n,
  tccs_req_if.sink                    in_ch,
  tccs_rsp_if.source                  out_ch,
  input  logic                        cfg_wr_en,
  input  logic [tccs_pkg::ATTR_W-1:0] cfg_wr_data
);
  import tccs_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  tccs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tccs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (in_ch.req_type),
    .in_char_code   (in_ch.char_code),
    .in_cell_color  (in_ch.cell_color),
    .in_col         (in_ch.col),
    .in_row         (in_ch.row),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_read_char  (out_ch.read_char),
    .out_read_color (out_ch.read_color),
    .out_cursor_row (out_ch.cursor_row),
    .out_cursor_col (out_ch.cursor_col),
    .out_scrolled   (out_ch.scrolled)
  );

  // Only one request is in flight, so an accepted beat closes the input.
  a_single_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while a request is in flight");

  // A scroll always leaves the cursor at the start of the bottom line.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.scrolled |->
      (out_ch.cursor_row == ROW_W'(ROWS - 1)) && (out_ch.cursor_col == '0))
    else $error("scroll result with cursor off the bottom line start");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      ({1'b0, out_ch.cursor_col} < (COL_W+1)'(COLUMNS)) &&
      ({1'b0, out_ch.cursor_row} < (ROW_W+1)'(ROWS)))
    else $error("cursor outside the screen");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for text_console_cursor_scroll: directed table, then random phases.
// Depends on tccs_pkg, tccs_req_if, tccs_rsp_if and the core RTL.
module tb;
  import tccs_pkg::*;

  localparam int STALL_LIMIT = 10000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    req_type_t         kind;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] cell_color;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } req_beat_t;

  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic [ATTR_W-1:0] read_color;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              scrolled;
  } console_result_t;

  typedef struct {
    req_beat_t       beat;
    int              reps;
    bit              typed;
    console_result_t want;
  } plan_row_t;

  localparam console_result_t ZERO_RES = '0;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [ATTR_W-1:0] cfg_wr_data;

  tccs_req_if in_ch ();
  tccs_rsp_if out_ch ();

  text_console_cursor_scroll DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  logic [CELL_W-1:0] shadow_cells [0:CELLS-1];
  logic [ROW_W-1:0]  shadow_row;
  logic [COL_W-1:0]  shadow_col;
  logic [ATTR_W-1:0] shadow_color;

  console_result_t expected_results [$];
  int mismatches;
  bit calm;
  bit typed_flag;
  console_result_t typed_want;

  plan_row_t directed_plan [0:24] = '{
    '{'{REQ_READ,     8'h00, 8'h00, 7'd0,   5'd0},  1,  1'b1, '{8'h20, 8'h0A, 5'd0, 7'd0, 1'b0}},
    '{'{REQ_READ,     8'h00, 8'h00, 7'd79,  5'd24}, 1,  1'b1, '{8'h20, 8'h0A, 5'd0, 7'd0, 1'b0}},
    '{'{REQ_READ,     8'h00, 8'h00, 7'd127, 5'd0},  1,  1'b1, ZERO_RES},
    '{'{REQ_READ,     8'h00, 8'h00, 7'd0,   5'd31}, 1,  1'b1, ZERO_RES},
    '{'{REQ_NOP,      8'hFF, 8'hFF, 7'd127, 5'd31}, 1,  1'b1, ZERO_RES},
    '{'{REQ_PUT_CELL, 8'hFF, 8'hFF, 7'd127, 5'd31}, 1,  1'b1, ZERO_RES},
    '{'{REQ_PUT_CELL, 8'hFF, 8'hFF, 7'd79,  5'd24}, 1,  1'b1, ZERO_RES},
    '{'{REQ_READ,     8'h00, 8'h00, 7'd79,  5'd24}, 1,  1'b1, '{8'hFF, 8'hFF, 5'd0, 7'd0, 1'b0}},
    '{'{REQ_PUT_CELL, 8'h00, 8'h00, 7'd0,   5'd0},  1,  1'b1, ZERO_RES},
    '{'{REQ_READ,     8'hFF, 8'hFF, 7'd0,   5'd0},  1,  1'b1, ZERO_RES},
    '{'{REQ_PUT_CHAR, 8'h41, 8'h00, 7'd0,   5'd0},  1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd1, 1'b0}},
    '{'{REQ_PUT_CHAR, 8'h0A, 8'h00, 7'd0,   5'd0},  1,  1'b1, '{8'h00, 8'h00, 5'd1, 7'd0, 1'b0}},
    '{'{REQ_PUT_CHAR, 8'hFF, 8'h00, 7'd0,   5'd0},  1,  1'b0, ZERO_RES},
    '{'{REQ_PUT_CHAR, 8'h00, 8'hFF, 7'd127, 5'd31}, 1,  1'b0, ZERO_RES},
    '{'{REQ_READ,     8'h00, 8'h00, 7'd0,   5'd1},  1,  1'b0, ZERO_RES},
    '{'{REQ_PUT_CELL, 8'h5A, 8'h3C, 7'd80,  5'd24}, 1,  1'b0, ZERO_RES},
    '{'{REQ_PUT_CELL, 8'h5A, 8'h3C, 7'd0,   5'd25}, 1,  1'b0, ZERO_RES},
    '{'{REQ_PUT_CHAR, 8'h0A, 8'h00, 7'd0,   5'd0},  23, 1'b0, ZERO_RES},
    '{'{REQ_PUT_CHAR, 8'h0A, 8'h00, 7'd0,   5'd0},  1,  1'b0, ZERO_RES},
    '{'{REQ_READ,     8'h00, 8'h00, 7'd0,   5'd24}, 1,  1'b0, ZERO_RES},
    '{'{REQ_READ,     8'h00, 8'h00, 7'd79,  5'd23}, 1,  1'b0, ZERO_RES},
    '{'{REQ_PUT_CHAR, 8'h55, 8'h00, 7'd0,   5'd0},  79, 1'b0, ZERO_RES},
    '{'{REQ_PUT_CHAR, 8'h7E, 8'h00, 7'd0,   5'd0},  1,  1'b0, ZERO_RES},
    '{'{REQ_READ,     8'h00, 8'h00, 7'd79,  5'd23}, 1,  1'b0, ZERO_RES},
    '{'{REQ_READ,     8'h00, 8'h00, 7'd0,   5'd0},  1,  1'b0, ZERO_RES}
  };

  function automatic logic advance_row();
    if (shadow_row == ROW_W'(ROWS - 1)) begin
      for (int i = 0; i + COLUMNS < CELLS; i++) begin
        shadow_cells[i] = shadow_cells[i + COLUMNS];
      end
      for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) begin
        shadow_cells[i] = {shadow_color, SPACE_CODE};
      end
      return 1'b1;
    end
    shadow_row = shadow_row + 1'b1;
    return 1'b0;
  endfunction

  function automatic console_result_t console_step(req_beat_t rq);
    console_result_t res;
    bit in_range;
    int idx;
    res = '0;
    in_range = (rq.col < COLUMNS) && (rq.row < ROWS);
    case (rq.kind)
      REQ_PUT_CHAR: begin
        if (rq.char_code == NEWLINE_CODE) begin
          shadow_col = '0;
          res.scrolled = advance_row();
        end else begin
          idx = int'(shadow_row) * COLUMNS + int'(shadow_col);
          shadow_cells[idx] = {shadow_color, rq.char_code};
          if (shadow_col == COL_W'(COLUMNS - 1)) begin
            shadow_col = '0;
            res.scrolled = advance_row();
          end else begin
            shadow_col = shadow_col + 1'b1;
          end
        end
      end
      REQ_PUT_CELL: begin
        if (in_range) begin
          shadow_cells[int'(rq.row) * COLUMNS + int'(rq.col)] = {rq.cell_color, rq.char_code};
        end
      end
      REQ_READ: begin
        if (in_range) begin
          {res.read_color, res.read_char} = shadow_cells[int'(rq.row) * COLUMNS + int'(rq.col)];
        end
      end
      default: ;
    endcase
    res.cursor_row = shadow_row;
    res.cursor_col = shadow_col;
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = calm || ($urandom_range(0, 99) >= 32);
    end
  end

  always @(posedge clk) begin
    req_beat_t beat;
    console_result_t want;
    console_result_t got;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      beat.kind = req_type_t'(in_ch.req_type);
      beat.char_code = in_ch.char_code;
      beat.cell_color = in_ch.cell_color;
      beat.col = in_ch.col;
      beat.row = in_ch.row;
      want = console_step(beat);
      expected_results.push_back(typed_flag ? typed_want : want);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.read_char, out_ch.read_color, out_ch.cursor_row, out_ch.cursor_col,
              out_ch.scrolled};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: unexpected beat: char %h color %h row %0d col %0d scr %b",
                   got.read_char, got.read_color, got.cursor_row, got.cursor_col, got.scrolled);
        end
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: char/color/row/col/scr expected %h %h %0d %0d %b, got %h %h %0d %0d %b",
                     want.read_char, want.read_color, want.cursor_row, want.cursor_col,
                     want.scrolled, got.read_char, got.read_color, got.cursor_row,
                     got.cursor_col, got.scrolled);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_req(req_beat_t beat, bit typed, console_result_t want);
    @(negedge clk);
    if (!calm) begin
      while ($urandom_range(0, 99) < 32) begin
        in_ch.valid = 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid = 1'b1;
    in_ch.req_type = beat.kind;
    in_ch.char_code = beat.char_code;
    in_ch.cell_color = beat.cell_color;
    in_ch.col = beat.col;
    in_ch.row = beat.row;
    typed_flag = typed;
    typed_want = want;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    typed_flag = 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_text_color(logic [ATTR_W-1:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    shadow_color = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic run_phase(int count, int newline_pct);
    req_beat_t beat;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      beat.char_code = CHAR_W'($urandom_range(0, 255));
      beat.cell_color = ATTR_W'($urandom_range(0, 255));
      beat.col = COL_W'($urandom_range(0, 127));
      beat.row = ROW_W'($urandom_range(0, 31));
      if (pick < 48) begin
        beat.kind = REQ_PUT_CHAR;
        if ($urandom_range(0, 99) < newline_pct) beat.char_code = NEWLINE_CODE;
      end else if (pick < 95) begin
        beat.kind = (pick < 68) ? REQ_PUT_CELL : REQ_READ;
        if ($urandom_range(0, 99) < 90) begin
          beat.col = COL_W'($urandom_range(0, COLUMNS - 1));
          beat.row = ROW_W'($urandom_range(0, ROWS - 1));
          if (beat.kind == REQ_READ && $urandom_range(0, 1) == 0) beat.row = shadow_row;
        end
      end else begin
        beat.kind = REQ_NOP;
      end
      send_req(beat, 1'b0, ZERO_RES);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.char_code = '0;
    in_ch.cell_color = '0;
    in_ch.col = '0;
    in_ch.row = '0;
    mismatches = 0;
    calm = 1'b0;
    typed_flag = 1'b0;
    typed_want = '0;
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = {RESET_COLOR, SPACE_CODE};
    shadow_row = '0;
    shadow_col = '0;
    shadow_color = RESET_COLOR;

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_plan[i]) begin
      repeat (directed_plan[i].reps) begin
        send_req(directed_plan[i].beat, directed_plan[i].typed, directed_plan[i].want);
      end
    end
    drain();

    set_text_color(8'hFF);
    run_phase(120, 10);
    drain();
    set_text_color(8'h00);
    run_phase(120, 1);
    drain();
    set_text_color(ATTR_W'($urandom_range(0, 255)));
    calm = 1'b1;
    run_phase(100, 8);
    drain();
    calm = 1'b0;
    set_text_color(ATTR_W'($urandom_range(0, 255)));
    run_phase(120, 15);
    drain();
    set_text_color(RESET_COLOR);
    run_phase(115, 3);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/tccs_pkg.sv
rtl/core/tccs_req_if.sv
rtl/core/tccs_rsp_if.sv
rtl/core/tccs_ram.sv
rtl/core/tccs_ctrl.sv
rtl/core/tccs_dp.sv
rtl/core/text_console_cursor_scroll.sv
tb/tb.sv
